// ----- rtl/exception_stacking_sequencer_unit_defines.svh -----
// ============================================================================
// Exception stacking sequencer assertion macros
// Shared assertion forms for the RTL modules; clock clk, reset rst_n.
// ============================================================================
`ifndef EXCEPTION_STACKING_SEQUENCER_UNIT_DEFINES_SVH
`define EXCEPTION_STACKING_SEQUENCER_UNIT_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define ESS_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// A condition that must hold whenever a trigger is seen at the same edge.
`define ESS_ASSERT_IMPLIES(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

`endif

// ----- rtl/ess_pkg.sv -----
// ============================================================================
// Exception stacking sequencer package
// Item codes, register indexes, frame constants and the job descriptor.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package ess_pkg;

    // Input item actions.
    typedef enum logic [2:0] {
        ACT_WRITE  = 3'd0,
        ACT_RAISE  = 3'd1,
        ACT_CHECK  = 3'd2,
        ACT_RETURN = 3'd3,
        ACT_LOAD   = 3'd4,
        ACT_READ   = 3'd5
    } action_t;

    // Result kinds.
    typedef enum logic [2:0] {
        KIND_ACK      = 3'd0,
        KIND_MEM_WR   = 3'd1,
        KIND_MEM_RD   = 3'd2,
        KIND_REG_DATA = 3'd3,
        KIND_BAD_RET  = 3'd4,
        KIND_REJECT   = 3'd5
    } result_kind_t;

    // Register indexes.
    localparam logic [3:0] REG_R0      = 4'd0;
    localparam logic [3:0] REG_R12     = 4'd4;
    localparam logic [3:0] REG_LR      = 4'd5;
    localparam logic [3:0] REG_PC      = 4'd6;
    localparam logic [3:0] REG_APSR    = 4'd7;
    localparam logic [3:0] REG_SP      = 4'd8;
    localparam logic [3:0] REG_CONTROL = 4'd9;
    localparam logic [3:0] REG_IPSR    = 4'd10;
    localparam logic [3:0] REG_PENDING = 4'd11;

    // Stack frame and exception return constants.
    localparam logic [3:0]  FRAME_WORDS    = 4'd8;
    localparam logic [3:0]  FRAME_LAST     = 4'd7;
    localparam logic [31:0] FRAME_BYTES    = 32'h0000_0020;
    localparam logic [31:0] WORD_BYTES     = 32'h0000_0004;
    localparam logic [31:0] PSR_STACK_MASK = 32'hFFFF_FC00 | 32'h0000_01FF;
    localparam logic [31:0] APSR_KEEP_MASK = 32'hF000_0000;
    localparam logic [31:0] EXC_RET_HANDLER     = 32'hFFFF_FFF1;
    localparam logic [31:0] EXC_RET_THREAD_MAIN = 32'hFFFF_FFF9;
    localparam logic [31:0] EXC_RET_THREAD_PROC = 32'hFFFF_FFFD;
    localparam logic [3:0]  RET_CODE_HANDLER     = 4'h1;
    localparam logic [3:0]  RET_CODE_THREAD_MAIN = 4'h9;
    localparam logic [3:0]  RET_CODE_THREAD_PROC = 4'hD;

    // Mode flag bits: bit 0 handler mode, bit 1 process stack.
    localparam logic [1:0] MODE_THREAD_MAIN = 2'b00;
    localparam logic [1:0] MODE_HANDLER     = 2'b01;
    localparam logic [1:0] MODE_PROCESS     = 2'b10;

    // Job queue between front and back.
    localparam int unsigned QUEUE_DEPTH = 2;

    // What the back part has to emit for one item.
    typedef enum logic [1:0] {
        JOB_SINGLE = 2'd0,
        JOB_PUSH   = 2'd1,
        JOB_POP    = 2'd2
    } job_kind_t;

    typedef struct packed {
        job_kind_t          jk;
        result_kind_t       skind;
        logic [31:0]        sdata;
        logic               branch;
        logic [31:0]        base;
        logic [7:0][31:0]   frame;
        logic               hm_a;
        logic [4:0]         num_a;
        logic               hm_b;
        logic [4:0]         num_b;
    } job_t;

endpackage

`default_nettype wire

// ----- rtl/exception_stacking_sequencer_unit.sv -----
// ============================================================================
// Exception stacking sequencer
// Exception entry and return sequencing with an eight-word stack frame.
// ============================================================================
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   input   | in        | in_valid / in_stall  | action, reg_index, value
//   result  | out       | out_valid / out_stall| kind, mem_address, mem_data,
//           |           |                      | last, branch_taken,
//           |           |                      | handler_mode, exception_number
//
// An item is executed in the cycle it is accepted; its results leave at one
// per cycle when not stalled, through the output register: a single-result
// item gives one, an exception return eight and an entry nine (eight stores
// and the vector read). The result port, one bus access per cycle, sets this
// rate. in_stall rises when the two-entry job queue is full; out_stall holds
// the output register and the back part. No clearing pass follows reset.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module exception_stacking_sequencer_unit
    import ess_pkg::*;
#(
    parameter int unsigned NUM_EXCEPTIONS = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  action,
    input  wire logic [3:0]  reg_index,
    input  wire logic [31:0] value,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       kind,
    output logic [31:0]      mem_address,
    output logic [31:0]      mem_data,
    output logic             last,
    output logic             branch_taken,
    output logic             handler_mode,
    output logic [4:0]       exception_number
);

    logic accept;
    logic q_full;
    logic q_pop;
    logic head_valid;
    job_t new_job;
    job_t head;

    // An item is taken whenever the job queue has room.
    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    ess_front #(
        .NUM_EXCEPTIONS (NUM_EXCEPTIONS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .action    (action),
        .reg_index (reg_index),
        .value     (value),
        .job       (new_job)
    );

    ess_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_job   (new_job),
        .pop        (q_pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (q_full)
    );

    ess_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .head             (head),
        .head_valid       (head_valid),
        .pop              (q_pop),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .kind             (kind),
        .mem_address      (mem_address),
        .mem_data         (mem_data),
        .last             (last),
        .branch_taken     (branch_taken),
        .handler_mode     (handler_mode),
        .exception_number (exception_number)
    );

endmodule

`default_nettype wire

// ----- rtl/ess_queue.sv -----
// ============================================================================
// Exception stacking sequencer job queue
// Small register queue that decouples the front part from the back part.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

`include "exception_stacking_sequencer_unit_defines.svh"

module ess_queue
    import ess_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    input  wire logic pop,
    output job_t      head,
    output logic      head_valid,
    output logic      full
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    job_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Job storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head       = entry_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == DEPTH_C);

    `ESS_ASSERT_HOLDS(a_queue_count_range, count_reg <= DEPTH_C, "queue count beyond depth")
    `ESS_ASSERT_IMPLIES(a_queue_no_underflow, pop, count_reg != '0, "pop from empty queue")

endmodule

`default_nettype wire

// ----- rtl/ess_front.sv -----
// ============================================================================
// Exception stacking sequencer front part
// Holds the architectural state, decodes each item and queues its results.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

`include "exception_stacking_sequencer_unit_defines.svh"

module ess_front
    import ess_pkg::*;
#(
    parameter int unsigned NUM_EXCEPTIONS = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic [2:0]  action,
    input  wire logic [3:0]  reg_index,
    input  wire logic [31:0] value,
    output job_t             job
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_VECTOR,
        PH_POP
    } phase_t;

    logic [31:0]               saved_reg [5];
    logic [31:0]               saved_next [5];
    logic [31:0]               link_reg, link_next;
    logic [31:0]               pc_reg, pc_next;
    logic [31:0]               psr_reg, psr_next;
    logic [31:0]               sp_reg, sp_next;
    logic [1:0]                mode_reg, mode_next;
    logic [4:0]                active_reg, active_next;
    logic [NUM_EXCEPTIONS-1:0] pend_reg, pend_next;
    phase_t                    phase_reg, phase_next;
    logic [2:0]                pop_cnt_reg, pop_cnt_next;

    logic [NUM_EXCEPTIONS-1:0] pend_low;
    logic [4:0]                pend_num;
    logic [31:0]               read_data;
    logic                      read_ok;
    logic [31:0]               new_link;
    logic [31:0]               new_sp;

    // Lowest pending exception: isolate the lowest set bit, then encode it.
    always_comb
    begin
        pend_low = pend_reg & (~pend_reg + 1'b1);
        pend_num = '0;
        for (int i = 0; i < NUM_EXCEPTIONS; i++)
        begin
            pend_num = pend_num | (pend_low[i] ? 5'(i) : 5'd0);
        end
    end

    // Register read decoder.
    always_comb
    begin
        read_ok   = 1'b1;
        read_data = '0;
        unique case (reg_index) inside
            [REG_R0:REG_R12]: read_data = saved_reg[reg_index[2:0]];
            REG_LR:           read_data = link_reg;
            REG_PC:           read_data = pc_reg;
            REG_APSR:         read_data = psr_reg;
            REG_SP:           read_data = sp_reg;
            REG_CONTROL:      read_data = {30'd0, mode_reg};
            REG_IPSR:         read_data = {27'd0, active_reg};
            REG_PENDING:      read_data = 32'(pend_reg);
            default:          read_ok   = 1'b0;
        endcase
    end

    // Link value on entry depends on the mode that is left.
    always_comb
    begin
        if (mode_reg[0])
        begin
            new_link = EXC_RET_HANDLER;
        end
        else if (!mode_reg[1])
        begin
            new_link = EXC_RET_THREAD_MAIN;
        end
        else
        begin
            new_link = EXC_RET_THREAD_PROC;
        end
        new_sp = sp_reg - FRAME_BYTES;
    end

    // Item execution and job build.
    always_comb
    begin
        for (int r = 0; r < 5; r++)
        begin
            saved_next[r] = saved_reg[r];
        end
        link_next    = link_reg;
        pc_next      = pc_reg;
        psr_next     = psr_reg;
        sp_next      = sp_reg;
        mode_next    = mode_reg;
        active_next  = active_reg;
        pend_next    = pend_reg;
        phase_next   = phase_reg;
        pop_cnt_next = pop_cnt_reg;

        job        = '0;
        job.jk     = JOB_SINGLE;
        job.skind  = KIND_ACK;

        case (action)
            ACT_WRITE:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    job.skind = KIND_REJECT;
                end
                else
                begin
                    unique case (reg_index) inside
                        [REG_R0:REG_R12]: saved_next[reg_index[2:0]] = value;
                        REG_LR:           link_next   = value;
                        REG_PC:           pc_next     = value;
                        REG_APSR:         psr_next    = value;
                        REG_SP:           sp_next     = value;
                        REG_CONTROL:      mode_next   = value[1:0];
                        REG_IPSR:         active_next = value[4:0];
                        REG_PENDING:      pend_next   = value[NUM_EXCEPTIONS-1:0];
                        default:          job.skind   = KIND_REJECT;
                    endcase
                end
            end
            ACT_RAISE:
            begin
                pend_next = pend_reg | value[NUM_EXCEPTIONS-1:0];
            end
            ACT_CHECK:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    job.skind = KIND_REJECT;
                end
                else if (pend_reg != '0)
                begin
                    // Exception entry: push the frame and fetch the vector.
                    pend_next    = pend_reg & ~pend_low;
                    sp_next      = new_sp;
                    link_next    = new_link;
                    mode_next    = MODE_HANDLER;
                    active_next  = pend_num;
                    phase_next   = PH_VECTOR;
                    job.jk       = JOB_PUSH;
                    job.base     = new_sp;
                    job.frame[0] = saved_reg[0];
                    job.frame[1] = saved_reg[1];
                    job.frame[2] = saved_reg[2];
                    job.frame[3] = saved_reg[3];
                    job.frame[4] = saved_reg[4];
                    job.frame[5] = link_reg;
                    job.frame[6] = pc_reg - WORD_BYTES;
                    job.frame[7] = psr_reg & PSR_STACK_MASK;
                    job.hm_b     = 1'b1;
                    job.num_b    = pend_num;
                end
            end
            ACT_RETURN:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    job.skind = KIND_REJECT;
                end
                else
                begin
                    unique case (value[3:0])
                        RET_CODE_HANDLER:     mode_next = MODE_HANDLER;
                        RET_CODE_THREAD_MAIN: mode_next = MODE_THREAD_MAIN;
                        RET_CODE_THREAD_PROC: mode_next = MODE_PROCESS;
                        default:              job.skind = KIND_BAD_RET;
                    endcase
                    if (job.skind != KIND_BAD_RET)
                    begin
                        active_next  = '0;
                        phase_next   = PH_POP;
                        pop_cnt_next = '0;
                        job.jk       = JOB_POP;
                        job.base     = sp_reg;
                    end
                end
            end
            ACT_LOAD:
            begin
                unique case (phase_reg)
                    PH_VECTOR:
                    begin
                        pc_next    = value;
                        phase_next = PH_IDLE;
                        job.branch = 1'b1;
                    end
                    PH_POP:
                    begin
                        unique case (pop_cnt_reg)
                            3'd5:    link_next = value;
                            3'd6:    pc_next   = value;
                            3'd7:    psr_next  = value & APSR_KEEP_MASK;
                            default: saved_next[pop_cnt_reg] = value;
                        endcase
                        pop_cnt_next = pop_cnt_reg + 1'b1;
                        if (pop_cnt_reg == FRAME_LAST[2:0])
                        begin
                            sp_next     = sp_reg + FRAME_BYTES;
                            active_next = '0;
                            phase_next  = PH_IDLE;
                            job.branch  = 1'b1;
                        end
                    end
                    default:
                    begin
                        job.skind = KIND_REJECT;
                    end
                endcase
            end
            ACT_READ:
            begin
                if (read_ok)
                begin
                    job.skind = KIND_REG_DATA;
                    job.sdata = read_data;
                end
                else
                begin
                    job.skind = KIND_REJECT;
                end
            end
            default:
            begin
                job.skind = KIND_REJECT;
            end
        endcase

        // Frame pushes show the mode before entry; everything else the mode after.
        if (job.jk == JOB_PUSH)
        begin
            job.hm_a  = mode_reg[0];
            job.num_a = active_reg;
        end
        else
        begin
            job.hm_a  = mode_next[0];
            job.num_a = active_next;
        end
    end

    // Architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 5; r++)
            begin
                saved_reg[r] <= '0;
            end
            link_reg    <= '0;
            pc_reg      <= '0;
            psr_reg     <= '0;
            sp_reg      <= '0;
            mode_reg    <= MODE_THREAD_MAIN;
            active_reg  <= '0;
            pend_reg    <= '0;
            phase_reg   <= PH_IDLE;
            pop_cnt_reg <= '0;
        end
        else if (accept)
        begin
            for (int r = 0; r < 5; r++)
            begin
                saved_reg[r] <= saved_next[r];
            end
            link_reg    <= link_next;
            pc_reg      <= pc_next;
            psr_reg     <= psr_next;
            sp_reg      <= sp_next;
            mode_reg    <= mode_next;
            active_reg  <= active_next;
            pend_reg    <= pend_next;
            phase_reg   <= phase_next;
            pop_cnt_reg <= pop_cnt_next;
        end
    end

    `ESS_ASSERT_IMPLIES(a_vector_in_handler, phase_reg == PH_VECTOR, mode_reg[0], "vector fetch outside handler mode")
    `ESS_ASSERT_IMPLIES(a_pop_count_in_pop, pop_cnt_reg != 3'd0, phase_reg == PH_POP, "frame pop count set outside return")

endmodule

`default_nettype wire

// ----- rtl/ess_back.sv -----
// ============================================================================
// Exception stacking sequencer back part
// Expands the job at the queue head into results, one per cycle unless stalled.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

`include "exception_stacking_sequencer_unit_defines.svh"

module ess_back
    import ess_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire job_t   head,
    input  wire logic   head_valid,
    output logic        pop,
    output logic        out_valid,
    input  wire logic   out_stall,
    output logic [2:0]  kind,
    output logic [31:0] mem_address,
    output logic [31:0] mem_data,
    output logic        last,
    output logic        branch_taken,
    output logic        handler_mode,
    output logic [4:0]  exception_number
);

    logic [3:0]   cnt_reg, cnt_next;
    logic         valid_reg;
    result_kind_t kind_reg, res_kind;
    logic [31:0]  addr_reg, res_addr;
    logic [31:0]  data_reg, res_data;
    logic         last_reg, res_last;
    logic         branch_reg, res_branch;
    logic         hm_reg, res_hm;
    logic [4:0]   num_reg, res_num;
    logic [31:0]  step_addr;
    logic         advance;

    // Frame word address for the current step.
    assign step_addr = head.base + {27'd0, cnt_reg[2:0], 2'b00};

    // Result for the current step of the head job.
    always_comb
    begin
        res_kind   = head.skind;
        res_addr   = '0;
        res_data   = head.sdata;
        res_last   = 1'b1;
        res_branch = head.branch;
        res_hm     = head.hm_a;
        res_num    = head.num_a;
        unique case (head.jk)
            JOB_PUSH:
            begin
                res_branch = 1'b0;
                if (cnt_reg == FRAME_WORDS)
                begin
                    res_kind = KIND_MEM_RD;
                    res_addr = {25'd0, head.num_b, 2'b00};
                    res_data = '0;
                    res_hm   = head.hm_b;
                    res_num  = head.num_b;
                end
                else
                begin
                    res_kind = KIND_MEM_WR;
                    res_addr = step_addr;
                    res_data = head.frame[cnt_reg[2:0]];
                    res_last = 1'b0;
                end
            end
            JOB_POP:
            begin
                res_kind   = KIND_MEM_RD;
                res_addr   = step_addr;
                res_data   = '0;
                res_branch = 1'b0;
                res_last   = (cnt_reg == FRAME_LAST);
            end
            default:
            begin
                res_last = 1'b1;
            end
        endcase
    end

    // One result per cycle whenever the output register can take it.
    assign advance  = head_valid && (!valid_reg || !out_stall);
    assign pop      = advance && res_last;
    assign cnt_next = pop ? 4'd0 : (advance ? cnt_reg + 1'b1 : cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (!valid_reg || !out_stall)
            begin
                valid_reg <= head_valid;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            kind_reg   <= res_kind;
            addr_reg   <= res_addr;
            data_reg   <= res_data;
            last_reg   <= res_last;
            branch_reg <= res_branch;
            hm_reg     <= res_hm;
            num_reg    <= res_num;
        end
    end

    assign out_valid        = valid_reg;
    assign kind             = kind_reg;
    assign mem_address      = addr_reg;
    assign mem_data         = data_reg;
    assign last             = last_reg;
    assign branch_taken     = branch_reg;
    assign handler_mode     = hm_reg;
    assign exception_number = num_reg;

    `ESS_ASSERT_HOLDS(a_step_range, cnt_reg <= FRAME_WORDS, "result step beyond frame")
    `ESS_ASSERT_IMPLIES(a_step_needs_job, cnt_reg != 4'd0, head_valid, "job left the queue mid-sequence")

endmodule

`default_nettype wire
